FILE: rtl/per_channel_requantizer_assert.svh
// Assertion macros for the per-channel requantizer checker.
// Needs nothing else; included by the files that assert.
`ifndef PER_CHANNEL_REQUANTIZER_ASSERT_SVH
`define PER_CHANNEL_REQUANTIZER_ASSERT_SVH

// same-cycle implication, off during reset
`define PCR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("requantizer check failed");

// next-cycle implication, off during reset
`define PCR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("requantizer check failed");

// next-cycle implication, live through reset
`define PCR_ASSERT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("requantizer reset check failed");

`endif

FILE: rtl/pcr_pkg.sv
// Shared types and constants for the per-channel requantizer.
// No dependencies; imported by the top level and its checker.
package pcr_pkg;

  localparam int CHANNELS_DEF  = 64;
  localparam int ACC_WIDTH_DEF = 40;

  localparam int CMD_W    = 2;
  localparam int CH_W     = 6;
  localparam int CH_CMP_W = 11;
  localparam int BIAS_W   = 32;
  localparam int MULT_W   = 15;
  localparam int SHIFT_W  = 6;
  localparam int ZP_W     = 16;
  localparam int TIDX_W   = 8;
  localparam int VAL_W    = 16;
  localparam int LO_W     = 32;
  localparam int SAT_W    = 17;
  localparam int ZPS_W    = 18;

  localparam int TAB_DEPTH = 256;
  localparam logic [TIDX_W-1:0] TAB_OFS = 8'h80;

  localparam int SAT_HI = 65535;
  localparam int SAT_LO = -65536;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic signed [VAL_W-1:0] CLO_RST = -16'sd128;
  localparam logic signed [VAL_W-1:0] CHI_RST = 16'sd127;

  typedef enum logic [CMD_W-1:0] {
    CMD_PROC  = 2'd0,
    CMD_PARAM = 2'd1,
    CMD_TABLE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_PASS = 2'd0,
    MODE_REQ  = 2'd1,
    MODE_ACT  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE    = 3'd0,
    REG_BIAS_EN = 3'd1,
    REG_ZP_EN   = 3'd2,
    REG_RELU_EN = 3'd3,
    REG_TAB_EN  = 3'd4,
    REG_WIDE    = 3'd5,
    REG_CLO     = 3'd6,
    REG_CHI     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [BIAS_W-1:0] bias;
    logic [MULT_W-1:0]        mult;
    logic [SHIFT_W-1:0]       shift;
    logic signed [ZP_W-1:0]   zp;
  } chan_prm_t;

endpackage

FILE: rtl/per_channel_requantizer.sv
// Per-channel requantizer top level: parameter and table memories, six-stage datapath.
// Depends on pcr_pkg.
//
// Takes one word per cycle while in_ready is high and delivers one result per cycle
// sustained while out_ready is high. The six register stages are: channel
// parameter read, bias add, the 15-bit multiply, rounding add, shift with saturation
// and zero point, then clamp, activation and the registered table read. Parameter
// words take effect for the next word; table words are written at the table stage, so
// a table word affects exactly the process words behind it. Memories have no reset and
// no clearing pass: a channel or table entry must be loaded before it is used. Words
// that write parameters or table entries or carry an unused command yield no result; a
// stalled result holds at the output while the stages behind it keep filling.
module per_channel_requantizer import pcr_pkg::*; #(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [CMD_W-1:0]            in_cmd,
  input  logic signed [ACC_WIDTH-1:0] in_acc_value,
  input  logic [CH_W-1:0]             in_channel,
  input  logic signed [BIAS_W-1:0]    in_bias_value,
  input  logic [MULT_W-1:0]           in_multiplier,
  input  logic [SHIFT_W-1:0]          in_shift_amount,
  input  logic signed [ZP_W-1:0]      in_zero_point,
  input  logic [TIDX_W-1:0]           in_table_index,
  input  logic signed [VAL_W-1:0]     in_table_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [VAL_W-1:0]     out_value,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [CFG_AW-1:0]           paddr,
  input  logic [CFG_DW-1:0]           pwdata,
  output logic [CFG_DW-1:0]           prdata,
  output logic                        pready
);

  localparam int CH_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW      = ACC_WIDTH + 16;
  localparam int SW      = PW + 1;
  localparam int RND_LIM = ACC_WIDTH + 16;

  // configuration
  logic [1:0]              mode_r;
  logic                    bias_en_r, zp_en_r, relu_en_r, tab_en_r, wide_r;
  logic signed [VAL_W-1:0] clo_r, chi_r;
  logic                    cfg_wr;
  reg_idx_t                cfg_idx;
  logic                    mode_req, mode_act;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_PASS;
      bias_en_r <= 1'b0;
      zp_en_r   <= 1'b0;
      relu_en_r <= 1'b0;
      tab_en_r  <= 1'b0;
      wide_r    <= 1'b0;
      clo_r     <= CLO_RST;
      chi_r     <= CHI_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MODE:    mode_r    <= pwdata[1:0];
        REG_BIAS_EN: bias_en_r <= pwdata[0];
        REG_ZP_EN:   zp_en_r   <= pwdata[0];
        REG_RELU_EN: relu_en_r <= pwdata[0];
        REG_TAB_EN:  tab_en_r  <= pwdata[0];
        REG_WIDE:    wide_r    <= pwdata[0];
        REG_CLO:     clo_r     <= pwdata[VAL_W-1:0];
        REG_CHI:     chi_r     <= pwdata[VAL_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MODE:    prdata = {{(CFG_DW-2){1'b0}}, mode_r};
      REG_BIAS_EN: prdata = {{(CFG_DW-1){1'b0}}, bias_en_r};
      REG_ZP_EN:   prdata = {{(CFG_DW-1){1'b0}}, zp_en_r};
      REG_RELU_EN: prdata = {{(CFG_DW-1){1'b0}}, relu_en_r};
      REG_TAB_EN:  prdata = {{(CFG_DW-1){1'b0}}, tab_en_r};
      REG_WIDE:    prdata = {{(CFG_DW-1){1'b0}}, wide_r};
      REG_CLO:     prdata = CFG_DW'(clo_r);
      REG_CHI:     prdata = CFG_DW'(chi_r);
    endcase
  end

  assign mode_req = (mode_r == MODE_REQ);
  assign mode_act = (mode_r == MODE_ACT);

  // stage control
  logic vld1_r, vld2_r, vld3_r, vld4_r, vld5_r, vld6_r;
  logic twr1_r, twr2_r, twr3_r, twr4_r, twr5_r;
  logic free1, free2, free3, free4, free5, free6;
  logic mv1, mv2, mv3, mv4, mv5, ld1, ld6;
  logic acc_in;

  assign free6 = !vld6_r || out_ready;
  assign mv5   = vld5_r && (twr5_r || free6);
  assign ld6   = vld5_r && !twr5_r && free6;
  assign free5 = !vld5_r || mv5;
  assign mv4   = vld4_r && free5;
  assign free4 = !vld4_r || mv4;
  assign mv3   = vld3_r && free4;
  assign free3 = !vld3_r || mv3;
  assign mv2   = vld2_r && free3;
  assign free2 = !vld2_r || mv2;
  assign mv1   = vld1_r && free2;
  assign free1 = !vld1_r || mv1;

  assign in_ready  = free1;
  assign acc_in    = in_valid && free1;
  assign ld1       = acc_in && (in_cmd == CMD_PROC || in_cmd == CMD_TABLE);
  assign out_valid = vld6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
    end else begin
      if (free1) vld1_r <= ld1;
      if (free2) vld2_r <= mv1;
      if (free3) vld3_r <= mv2;
      if (free4) vld4_r <= mv3;
      if (free5) vld5_r <= mv4;
      if (free6) vld6_r <= ld6;
    end
  end

  // stage 1: channel parameter read
  chan_prm_t                   prm_mem [CHANNELS];
  chan_prm_t                   prm1_r;
  logic [CH_AW+CH_W-1:0]       ch_ext;
  logic [CH_AW-1:0]            in_addr;
  logic                        in_rng;
  logic                        rng1_r;
  logic signed [ACC_WIDTH-1:0] acc1_r;
  logic [TIDX_W-1:0]           tidx1_r, tidx2_r, tidx3_r, tidx4_r, tidx5_r;
  logic signed [VAL_W-1:0]     tval1_r, tval2_r, tval3_r, tval4_r, tval5_r;

  assign ch_ext  = (CH_AW+CH_W)'(in_channel);
  assign in_addr = ch_ext[CH_AW-1:0];
  assign in_rng  = CH_CMP_W'(in_channel) < CH_CMP_W'(CHANNELS);

  always_ff @(posedge clk) begin
    if (acc_in && in_cmd == CMD_PARAM && in_rng) begin
      prm_mem[in_addr] <= '{bias: in_bias_value, mult: in_multiplier,
                            shift: in_shift_amount, zp: in_zero_point};
    end
    if (ld1) begin
      prm1_r <= prm_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      acc1_r  <= in_acc_value;
      rng1_r  <= in_rng;
      twr1_r  <= (in_cmd == CMD_TABLE);
      tidx1_r <= in_table_index;
      tval1_r <= in_table_value;
    end
  end

  // stage 2: bias add, wrap at accumulator width
  chan_prm_t                   prm_eff;
  logic signed [ACC_WIDTH-1:0] acc2_nxt, acc2_r;
  logic signed [LO_W-1:0]      lo2_r, lo3_r, lo4_r;
  logic [MULT_W-1:0]           mult2_r;
  logic [SHIFT_W-1:0]          sh2_r, sh3_r, sh4_r;
  logic signed [ZP_W-1:0]      zp2_r, zp3_r, zp4_r;

  assign prm_eff  = rng1_r ? prm1_r : '0;
  assign acc2_nxt = bias_en_r ? acc1_r + ACC_WIDTH'(prm_eff.bias) : acc1_r;

  always_ff @(posedge clk) begin
    if (mv1) begin
      acc2_r  <= acc2_nxt;
      lo2_r   <= acc1_r[LO_W-1:0];
      mult2_r <= prm_eff.mult;
      sh2_r   <= prm_eff.shift;
      zp2_r   <= prm_eff.zp;
      twr2_r  <= twr1_r;
      tidx2_r <= tidx1_r;
      tval2_r <= tval1_r;
    end
  end

  // stage 3: multiply
  logic signed [PW-1:0] mul_a, mul_b, prod3_nxt, prod3_r;

  assign mul_a     = PW'(acc2_r);
  assign mul_b     = $signed(PW'(mult2_r));
  assign prod3_nxt = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (mv2) begin
      prod3_r <= prod3_nxt;
      lo3_r   <= lo2_r;
      sh3_r   <= sh2_r;
      zp3_r   <= zp2_r;
      twr3_r  <= twr2_r;
      tidx3_r <= tidx2_r;
      tval3_r <= tval2_r;
    end
  end

  // stage 4: add rounding constant
  logic signed [SW-1:0] rbit, sum4_nxt, sum4_r;

  assign rbit = (sh3_r != '0 && {1'b0, sh3_r} < (SHIFT_W+1)'(RND_LIM))
              ? $signed(SW'(1) << (sh3_r - SHIFT_W'(1))) : '0;
  assign sum4_nxt = SW'(prod3_r) + rbit;

  always_ff @(posedge clk) begin
    if (mv3) begin
      sum4_r  <= sum4_nxt;
      lo4_r   <= lo3_r;
      sh4_r   <= sh3_r;
      zp4_r   <= zp3_r;
      twr4_r  <= twr3_r;
      tidx4_r <= tidx3_r;
      tval4_r <= tval3_r;
    end
  end

  // stage 5: shift, saturate, zero point
  logic signed [SW-1:0]    shd;
  logic signed [SAT_W-1:0] sat;
  logic signed [ZPS_W-1:0] zps;
  logic signed [LO_W-1:0]  val5_nxt, val5_r;

  assign shd = sum4_r >>> sh4_r;

  always_comb begin
    priority if (shd > SW'(SAT_HI)) begin
      sat = SAT_W'(SAT_HI);
    end else if (shd < SW'(SAT_LO)) begin
      sat = SAT_W'(SAT_LO);
    end else begin
      sat = shd[SAT_W-1:0];
    end
  end

  assign zps      = zp_en_r ? ZPS_W'(sat) + ZPS_W'(zp4_r) : ZPS_W'(sat);
  assign val5_nxt = mode_req ? LO_W'(zps) : lo4_r;

  always_ff @(posedge clk) begin
    if (mv4) begin
      val5_r  <= val5_nxt;
      twr5_r  <= twr4_r;
      tidx5_r <= tidx4_r;
      tval5_r <= tval4_r;
    end
  end

  // stage 6: clamp, activation, table read
  logic signed [VAL_W-1:0] tab_mem [TAB_DEPTH];
  logic signed [LO_W-1:0]  c_lo, c_hi, c_act;
  logic signed [VAL_W-1:0] val6_nxt, val6_r, tdat6_r, res;
  logic [TIDX_W-1:0]       taddr;
  logic                    tab_use6_r;

  assign c_lo     = (val5_r < LO_W'(clo_r)) ? LO_W'(clo_r) : val5_r;
  assign c_hi     = (c_lo > LO_W'(chi_r)) ? LO_W'(chi_r) : c_lo;
  assign c_act    = (relu_en_r && c_hi < 0) ? '0 : c_hi;
  assign val6_nxt = (mode_req || mode_act) ? c_act[VAL_W-1:0] : val5_r[VAL_W-1:0];
  assign taddr    = c_act[TIDX_W-1:0] ^ TAB_OFS;

  always_ff @(posedge clk) begin
    if (mv5 && twr5_r) begin
      tab_mem[tidx5_r] <= tval5_r;
    end
    if (ld6) begin
      tdat6_r <= tab_mem[taddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ld6) begin
      val6_r     <= val6_nxt;
      tab_use6_r <= tab_en_r && (mode_req || mode_act);
    end
  end

  assign res       = tab_use6_r ? tdat6_r : val6_r;
  assign out_value = wide_r ? res : {{(VAL_W-8){res[7]}}, res[7:0]};

endmodule

FILE: rtl/per_channel_requantizer_chk.sv
// Port-level checker for the per-channel requantizer, bound to the top level.
// Depends on pcr_pkg and per_channel_requantizer_assert.svh.
`include "per_channel_requantizer_assert.svh"

module per_channel_requantizer_chk import pcr_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [VAL_W-1:0] out_value,
  input logic                    psel,
  input logic                    penable,
  input logic                    pwrite,
  input logic                    pready,
  input logic [CFG_AW-1:0]       paddr,
  input logic [CFG_DW-1:0]       pwdata
);

  logic [1:0] mode_s_r;
  logic       relu_s_r, tab_s_r, wide_s_r;
  logic       wr;
  reg_idx_t   idx;

  assign wr  = psel && penable && pwrite && pready;
  assign idx = reg_idx_t'(paddr[CFG_AW-1:2]);

  // shadow the mode, relu, table and wide registers that shape the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_s_r <= MODE_PASS;
      relu_s_r <= 1'b0;
      tab_s_r  <= 1'b0;
      wide_s_r <= 1'b0;
    end else if (wr) begin
      if (idx == REG_MODE)    mode_s_r <= pwdata[1:0];
      if (idx == REG_RELU_EN) relu_s_r <= pwdata[0];
      if (idx == REG_TAB_EN)  tab_s_r  <= pwdata[0];
      if (idx == REG_WIDE)    wide_s_r <= pwdata[0];
    end
  end

  `PCR_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_value))
  `PCR_ASSERT_IMP(a_full_only, clk, rst_n, !in_ready, out_valid && !out_ready)
  `PCR_ASSERT_IMP(a_narrow_sext, clk, rst_n, out_valid && !wide_s_r, out_value[15:8] == {8{out_value[7]}})
  `PCR_ASSERT_IMP(a_relu_nonneg, clk, rst_n, out_valid && relu_s_r && !tab_s_r && wide_s_r && (mode_s_r == MODE_REQ || mode_s_r == MODE_ACT), !out_value[15])
  `PCR_ASSERT_RST(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind per_channel_requantizer per_channel_requantizer_chk u_chk (.*);

FILE: sim/tb.sv
// Self-checking bench for the per-channel requantizer: a directed table, then randomised phases.
// Depends on pcr_pkg and the per_channel_requantizer top level; most directed words carry
// their own expected value; others use a behavioural model fed every word and register write.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pcr_pkg::*;

  localparam int LIMIT       = 200000;
  localparam int PHASES      = 12;
  localparam int PHASE_WORDS = 45;
  localparam int DRAIN       = 12;

  localparam logic [CMD_W-1:0] CMD_SPARE  = 2'd3;
  localparam logic [1:0]       MODE_SPARE = 2'd3;

  localparam logic [39:0] ACC_MAX = 40'h7F_FFFF_FFFF;
  localparam logic [39:0] ACC_MIN = 40'h80_0000_0000;

  typedef struct {
    bit          is_cfg;
    reg_idx_t    ridx;
    logic [31:0] rval;
    logic [1:0]  cmd;
    logic [39:0] acc;
    logic [5:0]  ch;
    logic [31:0] bias;
    logic [14:0] mult;
    logic [5:0]  shift;
    logic [15:0] zp;
    logic [7:0]  tidx;
    logic [15:0] tval;
    bit          typed;
    logic [15:0] want;
  } step_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [CMD_W-1:0]         in_cmd = CMD_PROC;
  logic signed [39:0]       in_acc_value = '0;
  logic [CH_W-1:0]          in_channel = '0;
  logic signed [BIAS_W-1:0] in_bias_value = '0;
  logic [MULT_W-1:0]        in_multiplier = '0;
  logic [SHIFT_W-1:0]       in_shift_amount = '0;
  logic signed [ZP_W-1:0]   in_zero_point = '0;
  logic [TIDX_W-1:0]        in_table_index = '0;
  logic signed [VAL_W-1:0]  in_table_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [VAL_W-1:0]  out_value;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [CFG_AW-1:0]        paddr = '0;
  logic [CFG_DW-1:0]        pwdata = '0;
  logic [CFG_DW-1:0]        prdata;
  logic                     pready;

  // behavioural copy of the block's state and registers
  logic signed [31:0] ch_bias  [CHANNELS_DEF];
  logic [14:0]        ch_mult  [CHANNELS_DEF];
  logic [5:0]         ch_shift [CHANNELS_DEF];
  logic signed [15:0] ch_zp    [CHANNELS_DEF];
  logic signed [15:0] act_lut  [TAB_DEPTH];
  logic [1:0]         cur_mode = MODE_PASS;
  bit                 en_bias = 1'b0;
  bit                 en_zp = 1'b0;
  bit                 en_relu = 1'b0;
  bit                 en_lut = 1'b0;
  bit                 wide = 1'b0;
  logic signed [15:0] clo = CLO_RST;
  logic signed [15:0] chi = CHI_RST;

  logic [15:0] pending_out [$];
  bit          word_typed = 1'b0;
  logic [15:0] word_want = '0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  int          errors = 0;
  int          cycles = 0;

  per_channel_requantizer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_acc_value(in_acc_value), .in_channel(in_channel),
    .in_bias_value(in_bias_value), .in_multiplier(in_multiplier),
    .in_shift_amount(in_shift_amount), .in_zero_point(in_zero_point),
    .in_table_index(in_table_index), .in_table_value(in_table_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_value(out_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint clamp_and_activate(longint v);
    logic [7:0] idx;
    if (v < clo) v = clo;
    if (v > chi) v = chi;
    if (en_relu && v < 0) v = 0;
    if (en_lut) begin
      idx = v[7:0] + TAB_OFS;
      v = act_lut[idx];
    end
    return v;
  endfunction

  function automatic logic [15:0] requantize(logic [39:0] acc_bits, logic [5:0] ch);
    longint      acc;
    longint      prod;
    longint      rnd;
    longint      mult;
    int unsigned sh;
    acc = $signed(acc_bits);
    case (cur_mode)
      MODE_REQ: begin
        if (en_bias) begin
          prod = acc + ch_bias[ch];
          acc = $signed(prod[ACC_WIDTH_DEF-1:0]);
        end
        mult = ch_mult[ch];
        prod = acc * mult;
        sh = ch_shift[ch];
        if (sh != 0) begin
          rnd = (sh < ACC_WIDTH_DEF + 16) ? (64'sd1 <<< (sh - 1)) : 64'sd0;
          prod = (prod + rnd) >>> sh;
        end
        if (prod > SAT_HI) prod = SAT_HI;
        else if (prod < SAT_LO) prod = SAT_LO;
        if (en_zp) prod = prod + ch_zp[ch];
        acc = clamp_and_activate(prod);
      end
      MODE_ACT: acc = clamp_and_activate($signed(acc_bits[31:0]));
      default: ;
    endcase
    return wide ? acc[15:0] : {{8{acc[7]}}, acc[7:0]};
  endfunction

  function automatic step_t noise();
    step_t        w;
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    w.is_cfg = 1'b0;
    w.ridx = REG_MODE;
    w.rval = '0;
    w.acc = r[39:0];
    w.bias = r[71:40];
    w.zp = r[87:72];
    w.tval = r[103:88];
    w.mult = r[118:104];
    w.cmd = r[120:119];
    w.ch = r[126:121];
    r = {$urandom, $urandom, $urandom, $urandom};
    w.shift = r[5:0];
    w.tidx = r[13:6];
    w.typed = 1'b0;
    w.want = '0;
    return w;
  endfunction

  function automatic step_t rand_word();
    step_t       w;
    int          pick;
    logic [63:0] r;
    longint      sv;
    w = noise();
    pick = $urandom_range(0, 99);
    if (pick < 70) w.cmd = CMD_PROC;
    else if (pick < 85) w.cmd = CMD_PARAM;
    else if (pick < 96) w.cmd = CMD_TABLE;
    else w.cmd = CMD_SPARE;
    r = {$urandom, $urandom};
    sv = r;
    if ($urandom_range(0, 3) != 0) begin
      sv = sv >>> (64 - $urandom_range(1, 24));
      w.acc = sv[39:0];
    end
    r = {$urandom, $urandom};
    sv = r;
    if ($urandom_range(0, 1) != 0) begin
      sv = sv >>> 47;
      w.bias = sv[31:0];
    end
    r = {$urandom, $urandom};
    sv = r;
    if ($urandom_range(0, 1) != 0) begin
      sv = sv >>> 55;
      w.zp = sv[15:0];
    end
    case ($urandom_range(0, 7))
      0: w.mult = '0;
      1: w.mult = '1;
      default: ;
    endcase
    if ($urandom_range(0, 7) != 0) w.shift = 6'($urandom_range(0, 24));
    return w;
  endfunction

  function automatic step_t mk_proc(logic [1:0] cmd, logic [39:0] acc, logic [5:0] ch,
                                    bit typed, logic [15:0] want);
    step_t w;
    w = noise();
    w.cmd = cmd;
    w.acc = acc;
    w.ch = ch;
    w.typed = typed;
    w.want = want;
    return w;
  endfunction

  function automatic step_t mk_param(logic [5:0] ch, logic [31:0] bias, logic [14:0] mult,
                                     logic [5:0] shift, logic [15:0] zp);
    step_t w;
    w = noise();
    w.cmd = CMD_PARAM;
    w.ch = ch;
    w.bias = bias;
    w.mult = mult;
    w.shift = shift;
    w.zp = zp;
    return w;
  endfunction

  function automatic step_t mk_table(logic [7:0] idx, logic [15:0] val);
    step_t w;
    w = noise();
    w.cmd = CMD_TABLE;
    w.tidx = idx;
    w.tval = val;
    return w;
  endfunction

  function automatic step_t mk_cfg(reg_idx_t r, logic [31:0] v);
    step_t w;
    w = noise();
    w.is_cfg = 1'b1;
    w.ridx = r;
    w.rval = v;
    return w;
  endfunction

  task automatic send_word(input step_t w);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_cmd <= w.cmd;
    in_acc_value <= w.acc;
    in_channel <= w.ch;
    in_bias_value <= w.bias;
    in_multiplier <= w.mult;
    in_shift_amount <= w.shift;
    in_zero_point <= w.zp;
    in_table_index <= w.tidx;
    in_table_value <= w.tval;
    word_typed <= w.typed;
    word_want <= w.want;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold until every result is in and the stages behind it are empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_out.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t r, input logic [31:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && psel && penable && pwrite && pready) begin
      case (reg_idx_t'(paddr[CFG_AW-1:2]))
        REG_MODE:    cur_mode = pwdata[1:0];
        REG_BIAS_EN: en_bias = pwdata[0];
        REG_ZP_EN:   en_zp = pwdata[0];
        REG_RELU_EN: en_relu = pwdata[0];
        REG_TAB_EN:  en_lut = pwdata[0];
        REG_WIDE:    wide = pwdata[0];
        REG_CLO:     clo = pwdata[15:0];
        REG_CHI:     chi = pwdata[15:0];
        default: ;
      endcase
    end
    if (rst_n && in_valid && in_ready) begin
      case (in_cmd)
        CMD_PROC: begin
          pending_out.push_back(word_typed ? word_want : requantize(in_acc_value, in_channel));
        end
        CMD_PARAM: begin
          ch_bias[in_channel] = in_bias_value;
          ch_mult[in_channel] = in_multiplier;
          ch_shift[in_channel] = in_shift_amount;
          ch_zp[in_channel] = in_zero_point;
        end
        CMD_TABLE: act_lut[in_table_index] = in_table_value;
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin : out_check
    logic [15:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_out.size() == 0) begin
        errors++;
        $display("%0t unexpected out_value: expected none, got %h", $time, out_value);
      end else begin
        want = pending_out.pop_front();
        if (out_value !== want) begin
          errors++;
          $display("%0t out_value mismatch: expected %h, got %h", $time, want, out_value);
        end
      end
    end
  end

  initial begin : sink
    int stall;
    wait (rst_n);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    step_t              steps [$];
    step_t              w;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // load every channel and table entry before anything reads them
    for (int i = 0; i < CHANNELS_DEF; i++) begin
      w = rand_word();
      w.cmd = CMD_PARAM;
      w.ch = 6'(i);
      send_word(w);
    end
    for (int i = 0; i < TAB_DEPTH; i++) begin
      w = rand_word();
      w.cmd = CMD_TABLE;
      w.tidx = 8'(i);
      send_word(w);
    end

    steps.push_back(mk_proc(CMD_PROC, ACC_MAX, 6'd0, 1'b1, 16'hFFFF));
    steps.push_back(mk_proc(CMD_PROC, ACC_MIN, 6'd0, 1'b1, 16'h0000));
    steps.push_back(mk_proc(CMD_PROC, 40'h80, 6'd0, 1'b1, 16'hFF80));
    steps.push_back(mk_proc(CMD_SPARE, ACC_MAX, 6'd0, 1'b0, 16'h0000));
    steps.push_back(mk_param(6'd0, 32'h7FFF_FFFF, 15'h7FFF, 6'd0, 16'h7FFF));
    steps.push_back(mk_param(6'd63, 32'h8000_0000, 15'h0000, 6'd63, 16'h8000));
    steps.push_back(mk_param(6'd1, 32'd100, 15'd1, 6'd1, 16'h0000));
    steps.push_back(mk_param(6'd2, 32'd0, 15'h7FFF, 6'd56, 16'h0000));
    steps.push_back(mk_cfg(REG_MODE, MODE_REQ));
    steps.push_back(mk_proc(CMD_PROC, 40'd1, 6'd1, 1'b1, 16'h0001));
    steps.push_back(mk_proc(CMD_PROC, 40'hFF_FFFF_FFFF, 6'd1, 1'b1, 16'h0000));
    steps.push_back(mk_proc(CMD_PROC, 40'd3, 6'd1, 1'b1, 16'h0002));
    steps.push_back(mk_proc(CMD_PROC, ACC_MAX, 6'd0, 1'b1, 16'h007F));
    steps.push_back(mk_proc(CMD_PROC, ACC_MIN, 6'd0, 1'b1, 16'hFF80));
    steps.push_back(mk_proc(CMD_PROC, ACC_MAX, 6'd63, 1'b1, 16'h0000));
    steps.push_back(mk_proc(CMD_PROC, ACC_MIN, 6'd2, 1'b1, 16'hFFFF));
    steps.push_back(mk_cfg(REG_BIAS_EN, 32'd1));
    steps.push_back(mk_proc(CMD_PROC, ACC_MAX, 6'd0, 1'b1, 16'hFF80));
    steps.push_back(mk_cfg(REG_ZP_EN, 32'd1));
    steps.push_back(mk_cfg(REG_WIDE, 32'd1));
    steps.push_back(mk_cfg(REG_CLO, 32'hFFFF_8000));
    steps.push_back(mk_cfg(REG_CHI, 32'h0000_7FFF));
    steps.push_back(mk_proc(CMD_PROC, 40'd0, 6'd0, 1'b1, 16'h7FFF));
    steps.push_back(mk_proc(CMD_PROC, 40'd5, 6'd63, 1'b1, 16'h8000));
    steps.push_back(mk_cfg(REG_RELU_EN, 32'd1));
    steps.push_back(mk_proc(CMD_PROC, 40'd5, 6'd63, 1'b1, 16'h0000));
    steps.push_back(mk_cfg(REG_CLO, 32'd10));
    steps.push_back(mk_cfg(REG_CHI, 32'd5));
    steps.push_back(mk_proc(CMD_PROC, 40'd0, 6'd1, 1'b1, 16'h0005));
    steps.push_back(mk_cfg(REG_MODE, MODE_ACT));
    steps.push_back(mk_proc(CMD_PROC, 40'h12_8000_0000, 6'd0, 1'b1, 16'h0005));
    steps.push_back(mk_cfg(REG_RELU_EN, 32'd0));
    steps.push_back(mk_cfg(REG_CLO, 32'hFFFF_8000));
    steps.push_back(mk_cfg(REG_CHI, 32'h0000_7FFF));
    steps.push_back(mk_cfg(REG_TAB_EN, 32'd1));
    steps.push_back(mk_table(8'd255, 16'h7FFF));
    steps.push_back(mk_table(8'd0, 16'h8000));
    steps.push_back(mk_proc(CMD_PROC, 40'd127, 6'd0, 1'b1, 16'h7FFF));
    steps.push_back(mk_proc(CMD_PROC, 40'hFF_FFFF_FF80, 6'd0, 1'b1, 16'h8000));
    steps.push_back(mk_proc(CMD_PROC, 40'hFF_0000_0000, 6'd0, 1'b0, 16'h0000));
    steps.push_back(mk_cfg(REG_MODE, MODE_SPARE));
    steps.push_back(mk_proc(CMD_PROC, 40'h55_1234_5678, 6'd0, 1'b1, 16'h5678));

    foreach (steps[k]) begin
      if (steps[k].is_cfg) begin
        drain();
        write_reg(steps[k].ridx, steps[k].rval);
      end else begin
        send_word(steps[k]);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      if (p < 4) write_reg(REG_MODE, 32'(p));
      else if ($urandom_range(0, 3) == 0) write_reg(REG_MODE, $urandom_range(0, 3));
      else write_reg(REG_MODE, MODE_REQ);
      write_reg(REG_BIAS_EN, $urandom_range(0, 1));
      write_reg(REG_ZP_EN, $urandom_range(0, 1));
      write_reg(REG_RELU_EN, $urandom_range(0, 1));
      write_reg(REG_TAB_EN, $urandom_range(0, 1));
      write_reg(REG_WIDE, $urandom_range(0, 1));
      case ((p / 2) % 4)
        0: begin lo = 16'sh8000; hi = 16'sh7FFF; end
        1: begin lo = CLO_RST; hi = CHI_RST; end
        2: begin lo = 16'($urandom); hi = 16'($urandom); end
        default: begin lo = 16'sh7FFF; hi = 16'sh8000; end
      endcase
      write_reg(REG_CLO, {{16{lo[15]}}, lo});
      write_reg(REG_CHI, {{16{hi[15]}}, hi});
      repeat (PHASE_WORDS) send_word(rand_word());
    end

    drain();
    if (pending_out.size() != 0) begin
      errors++;
      $display("%0t %0d expected results never arrived", $time, pending_out.size());
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
